// ----- rtl/mi4_pkg.sv -----
// shared types, constants and term tables for the 4x4 matrix inverse
package mi4_pkg;

    // exact products and sums fit well inside this width
    localparam int unsigned WIDE_W = 136;

    typedef logic [WIDE_W-1:0] t_wide;

    // one determinant term: four element indices and a subtract flag
    typedef struct packed {
        logic [3:0] a;
        logic [3:0] b;
        logic [3:0] c;
        logic [3:0] d;
        logic       sub;
    } t_det_term;

    // one cofactor term: three element indices and a subtract flag
    typedef struct packed {
        logic [3:0] a;
        logic [3:0] b;
        logic [3:0] c;
        logic       sub;
    } t_cof_term;

    function automatic t_det_term det_term(input logic [4:0] t);
        t_det_term r;
        r = '0;
        case (t)
            5'd0:  r = '{4'd12, 4'd9,  4'd6,  4'd3,  1'b0};
            5'd1:  r = '{4'd8,  4'd13, 4'd6,  4'd3,  1'b1};
            5'd2:  r = '{4'd12, 4'd5,  4'd10, 4'd3,  1'b1};
            5'd3:  r = '{4'd4,  4'd13, 4'd10, 4'd3,  1'b0};
            5'd4:  r = '{4'd8,  4'd5,  4'd14, 4'd3,  1'b0};
            5'd5:  r = '{4'd4,  4'd9,  4'd14, 4'd3,  1'b1};
            5'd6:  r = '{4'd12, 4'd9,  4'd2,  4'd7,  1'b1};
            5'd7:  r = '{4'd8,  4'd13, 4'd2,  4'd7,  1'b0};
            5'd8:  r = '{4'd12, 4'd1,  4'd10, 4'd7,  1'b0};
            5'd9:  r = '{4'd0,  4'd13, 4'd10, 4'd7,  1'b1};
            5'd10: r = '{4'd8,  4'd1,  4'd14, 4'd7,  1'b1};
            5'd11: r = '{4'd0,  4'd9,  4'd14, 4'd7,  1'b0};
            5'd12: r = '{4'd12, 4'd5,  4'd2,  4'd11, 1'b0};
            5'd13: r = '{4'd4,  4'd13, 4'd2,  4'd11, 1'b1};
            5'd14: r = '{4'd12, 4'd1,  4'd6,  4'd11, 1'b1};
            5'd15: r = '{4'd0,  4'd13, 4'd6,  4'd11, 1'b0};
            5'd16: r = '{4'd4,  4'd1,  4'd14, 4'd11, 1'b0};
            5'd17: r = '{4'd0,  4'd5,  4'd14, 4'd11, 1'b1};
            5'd18: r = '{4'd8,  4'd5,  4'd2,  4'd15, 1'b1};
            5'd19: r = '{4'd4,  4'd9,  4'd2,  4'd15, 1'b0};
            5'd20: r = '{4'd8,  4'd1,  4'd6,  4'd15, 1'b0};
            5'd21: r = '{4'd0,  4'd9,  4'd6,  4'd15, 1'b1};
            5'd22: r = '{4'd4,  4'd1,  4'd10, 4'd15, 1'b1};
            5'd23: r = '{4'd0,  4'd5,  4'd10, 4'd15, 1'b0};
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic t_cof_term cof_term(input logic [3:0] k, input logic [2:0] t);
        logic [15:0] x;
        t_cof_term   r;
        x = '0;
        case ({k, t})
            {4'd0, 3'd0}: x = 16'h9E70; {4'd0, 3'd1}: x = 16'hDA71;
            {4'd0, 3'd2}: x = 16'hD6B0; {4'd0, 3'd3}: x = 16'h5EB1;
            {4'd0, 3'd4}: x = 16'h96F1; {4'd0, 3'd5}: x = 16'h5AF0;
            {4'd1, 3'd0}: x = 16'hDA30; {4'd1, 3'd1}: x = 16'h9E31;
            {4'd1, 3'd2}: x = 16'hD2B1; {4'd1, 3'd3}: x = 16'h1EB0;
            {4'd1, 3'd4}: x = 16'h92F0; {4'd1, 3'd5}: x = 16'h1AF1;
            {4'd2, 3'd0}: x = 16'h5E30; {4'd2, 3'd1}: x = 16'hD631;
            {4'd2, 3'd2}: x = 16'hD270; {4'd2, 3'd3}: x = 16'h1E71;
            {4'd2, 3'd4}: x = 16'h52F1; {4'd2, 3'd5}: x = 16'h16F0;
            {4'd3, 3'd0}: x = 16'h9630; {4'd3, 3'd1}: x = 16'h5A31;
            {4'd3, 3'd2}: x = 16'h9271; {4'd3, 3'd3}: x = 16'h1A70;
            {4'd3, 3'd4}: x = 16'h52B0; {4'd3, 3'd5}: x = 16'h16B1;
            {4'd4, 3'd0}: x = 16'hCA70; {4'd4, 3'd1}: x = 16'h8E71;
            {4'd4, 3'd2}: x = 16'hC6B1; {4'd4, 3'd3}: x = 16'h4EB0;
            {4'd4, 3'd4}: x = 16'h86F0; {4'd4, 3'd5}: x = 16'h4AF1;
            {4'd5, 3'd0}: x = 16'h8E30; {4'd5, 3'd1}: x = 16'hCA31;
            {4'd5, 3'd2}: x = 16'hC2B0; {4'd5, 3'd3}: x = 16'h0EB1;
            {4'd5, 3'd4}: x = 16'h82F1; {4'd5, 3'd5}: x = 16'h0AF0;
            {4'd6, 3'd0}: x = 16'hC630; {4'd6, 3'd1}: x = 16'h4E31;
            {4'd6, 3'd2}: x = 16'hC271; {4'd6, 3'd3}: x = 16'h0E70;
            {4'd6, 3'd4}: x = 16'h42F0; {4'd6, 3'd5}: x = 16'h06F1;
            {4'd7, 3'd0}: x = 16'h4A30; {4'd7, 3'd1}: x = 16'h8631;
            {4'd7, 3'd2}: x = 16'h8270; {4'd7, 3'd3}: x = 16'h0A71;
            {4'd7, 3'd4}: x = 16'h42B1; {4'd7, 3'd5}: x = 16'h06B0;
            {4'd8, 3'd0}: x = 16'h8D70; {4'd8, 3'd1}: x = 16'hC971;
            {4'd8, 3'd2}: x = 16'hC5B0; {4'd8, 3'd3}: x = 16'h4DB1;
            {4'd8, 3'd4}: x = 16'h85F1; {4'd8, 3'd5}: x = 16'h49F0;
            {4'd9, 3'd0}: x = 16'hC930; {4'd9, 3'd1}: x = 16'h8D31;
            {4'd9, 3'd2}: x = 16'hC1B1; {4'd9, 3'd3}: x = 16'h0DB0;
            {4'd9, 3'd4}: x = 16'h81F0; {4'd9, 3'd5}: x = 16'h09F1;
            {4'd10, 3'd0}: x = 16'h4D30; {4'd10, 3'd1}: x = 16'hC531;
            {4'd10, 3'd2}: x = 16'hC170; {4'd10, 3'd3}: x = 16'h0D71;
            {4'd10, 3'd4}: x = 16'h41F1; {4'd10, 3'd5}: x = 16'h05F0;
            {4'd11, 3'd0}: x = 16'h8530; {4'd11, 3'd1}: x = 16'h4931;
            {4'd11, 3'd2}: x = 16'h8171; {4'd11, 3'd3}: x = 16'h0970;
            {4'd11, 3'd4}: x = 16'h41B0; {4'd11, 3'd5}: x = 16'h05B1;
            {4'd12, 3'd0}: x = 16'hC960; {4'd12, 3'd1}: x = 16'h8D61;
            {4'd12, 3'd2}: x = 16'hC5A1; {4'd12, 3'd3}: x = 16'h4DA0;
            {4'd12, 3'd4}: x = 16'h85E0; {4'd12, 3'd5}: x = 16'h49E1;
            {4'd13, 3'd0}: x = 16'h8D20; {4'd13, 3'd1}: x = 16'hC921;
            {4'd13, 3'd2}: x = 16'hC1A0; {4'd13, 3'd3}: x = 16'h0DA1;
            {4'd13, 3'd4}: x = 16'h81E1; {4'd13, 3'd5}: x = 16'h09E0;
            {4'd14, 3'd0}: x = 16'hC520; {4'd14, 3'd1}: x = 16'h4D21;
            {4'd14, 3'd2}: x = 16'hC161; {4'd14, 3'd3}: x = 16'h0D60;
            {4'd14, 3'd4}: x = 16'h41E0; {4'd14, 3'd5}: x = 16'h05E1;
            {4'd15, 3'd0}: x = 16'h4920; {4'd15, 3'd1}: x = 16'h8521;
            {4'd15, 3'd2}: x = 16'h8160; {4'd15, 3'd3}: x = 16'h0961;
            {4'd15, 3'd4}: x = 16'h41A1; {4'd15, 3'd5}: x = 16'h05A0;
            default: x = '0;
        endcase
        r.a   = x[15:12];
        r.b   = x[11:8];
        r.c   = x[7:4];
        r.sub = x[0];
        return r;
    endfunction

endpackage

// ----- rtl/matrix_inverse_4x4.sv -----
// top level: sequenced 4x4 fixed-point matrix inverse by cofactors and adjugate
//
// Elements enter one per transfer in storage order 0 to 15, one per cycle while
// loading. After the sixteenth the block stalls its input and computes on one
// shared 33x32 signed multiplier and one shared restoring divider. Every wide
// product is built a 32-bit limb at a time. The determinant needs 24 terms of
// three multiplies. Each of the 16 results needs 6 terms of two multiplies, a
// sign/shift step, a one-bit-per-cycle division of 136 + 2*FRAC_BITS steps plus
// a finishing step, and an output step that waits while a stalled result still
// holds the output register. A singular matrix is returned as loaded with no
// division, one result per cycle after the determinant while the output is not
// stalled. Results leave through an output register and the next matrix load
// starts once the sixteenth result has entered that register.
module matrix_inverse_4x4 #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_element_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_result_value,
    output logic [3:0]         o_result_index,
    output logic               o_singular,
    output logic               o_saturated,
    output logic               o_last
);

    localparam int unsigned W      = mi4_pkg::WIDE_W;
    localparam int unsigned MC_W   = 96;
    localparam int unsigned NUM_W  = W + 2 * FRAC_BITS;
    localparam int unsigned DIV_N  = NUM_W;
    localparam int unsigned DCNT_W = $clog2(DIV_N + 1);

    // sequencer states
    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_DET  = 3'd1;
    localparam logic [2:0] S_COF  = 3'd2;
    localparam logic [2:0] S_PREP = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;
    localparam logic [2:0] S_SING = 3'd6;

    logic [2:0]  r_state, n_state;
    logic [3:0]  r_load, n_load;
    logic [4:0]  r_term, n_term;
    logic [1:0]  r_mstep, n_mstep;
    logic [1:0]  r_limb, n_limb;
    logic [3:0]  r_k, n_k;

    logic [31:0] r_elem [16];

    mi4_pkg::t_wide  r_det, n_det;
    mi4_pkg::t_wide  r_acc, n_acc;
    mi4_pkg::t_wide  r_macc, n_macc;
    logic [MC_W-1:0] r_prod, n_prod;
    mi4_pkg::t_wide  r_dmag, n_dmag;
    logic            r_dneg, n_dneg;
    logic            r_nneg, n_nneg;

    logic [NUM_W-1:0] r_num, n_num;
    logic [W:0]       r_rem, n_rem;
    logic [DCNT_W-1:0] r_dcnt, n_dcnt;

    logic               r_ovalid, n_ovalid;
    logic signed [31:0] r_oval, n_oval;
    logic [3:0]         r_oidx, n_oidx;
    logic               r_osing, n_osing;
    logic               r_osat, n_osat;

    logic                accept_in;
    logic                out_free;
    mi4_pkg::t_det_term  dt;
    mi4_pkg::t_cof_term  ct;
    logic [3:0]          msel;
    logic [3:0]          fsel;
    logic signed [31:0]  mop;
    logic [MC_W-1:0]     mcand;
    logic [31:0]         mlimb;
    logic signed [32:0]  mlimb_s;
    logic signed [64:0]  mpart;
    mi4_pkg::t_wide      mpart_sh;
    logic                acc_last;
    logic                tsub;
    mi4_pkg::t_wide      macc_base;
    mi4_pkg::t_wide      psum;
    logic [W:0]          rem_sh;
    logic [W:0]          rem_sub;
    logic                qneg;
    logic                qhigh;
    logic [31:0]         qlow;

    assign accept_in = i_valid && !o_stall;
    assign o_stall   = (r_state != S_LOAD);
    assign out_free  = !r_ovalid || !i_stall;

    assign dt = mi4_pkg::det_term(r_term);
    assign ct = mi4_pkg::cof_term(r_k, r_term[2:0]);

    // operand pick for the shared multiplier
    always_comb begin
        msel = dt.a;
        if (r_state == S_DET) begin
            case (r_mstep)
                2'd0: msel = dt.b;
                2'd1: msel = dt.c;
                2'd2: msel = dt.d;
                default: msel = dt.a;
            endcase
        end else begin
            case (r_mstep)
                2'd0: msel = ct.b;
                2'd1: msel = ct.c;
                default: msel = ct.a;
            endcase
        end
    end

    assign mop = $signed(r_elem[msel]);

    // multiplicand: first element of the term, then the running product
    assign fsel  = (r_state == S_DET) ? dt.a : ct.a;
    assign mcand = (r_mstep == 2'd0) ? {{(MC_W-32){r_elem[fsel][31]}}, r_elem[fsel]}
                                     : r_prod;

    // limb pick, top limb signed
    always_comb begin
        case (r_limb)
            2'd0: mlimb = mcand[31:0];
            2'd1: mlimb = mcand[63:32];
            default: mlimb = mcand[95:64];
        endcase
    end

    assign mlimb_s  = $signed({(r_limb == 2'd2) && mlimb[31], mlimb});
    assign mpart    = mlimb_s * mop;
    assign mpart_sh = {{(W-65){mpart[64]}}, mpart} << {r_limb, 5'd0};

    // limb accumulation, the last multiply of a term folds into its sum
    assign acc_last  = (r_state == S_DET) ? (r_mstep == 2'd2) : (r_mstep == 2'd1);
    assign tsub      = (r_state == S_DET) ? dt.sub : ct.sub;
    assign macc_base = (r_limb != 2'd0) ? r_macc
                     : (acc_last ? ((r_state == S_DET) ? r_det : r_acc) : '0);
    assign psum      = (acc_last && tsub) ? macc_base - mpart_sh : macc_base + mpart_sh;

    // one restoring division step
    assign rem_sh  = {r_rem[W-1:0], r_num[NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_dmag};

    // quotient range check on the completed quotient (held in r_num)
    assign qneg  = r_nneg ^ r_dneg;
    assign qhigh = |r_num[NUM_W-1:32];
    assign qlow  = r_num[31:0];

    // element store writes
    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_elem[r_load] <= i_element_value;
        end
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_load   = r_load;
        n_term   = r_term;
        n_mstep  = r_mstep;
        n_limb   = r_limb;
        n_k      = r_k;
        n_det    = r_det;
        n_acc    = r_acc;
        n_macc   = r_macc;
        n_prod   = r_prod;
        n_dmag   = r_dmag;
        n_dneg   = r_dneg;
        n_nneg   = r_nneg;
        n_num    = r_num;
        n_rem    = r_rem;
        n_dcnt   = r_dcnt;
        n_ovalid = r_ovalid && i_stall;
        n_oval   = r_oval;
        n_oidx   = r_oidx;
        n_osing  = r_osing;
        n_osat   = r_osat;
        case (r_state)
            S_LOAD: begin
                if (accept_in) begin
                    n_load = r_load + 4'd1;
                    if (r_load == 4'd15) begin
                        n_state = S_DET;
                        n_term  = '0;
                        n_mstep = 2'd0;
                        n_limb  = 2'd0;
                        n_det   = '0;
                    end
                end
            end
            S_DET: begin
                n_macc = psum;
                if (r_limb != 2'd2) begin
                    n_limb = r_limb + 2'd1;
                end else begin
                    n_limb = 2'd0;
                    if (r_mstep != 2'd2) begin
                        n_prod  = psum[MC_W-1:0];
                        n_mstep = r_mstep + 2'd1;
                    end else begin
                        n_mstep = 2'd0;
                        n_det   = psum;
                        if (r_term == 5'd23) begin
                            n_term  = '0;
                            n_k     = '0;
                            n_acc   = '0;
                            n_state = (psum == '0) ? S_SING : S_COF;
                        end else begin
                            n_term = r_term + 5'd1;
                        end
                    end
                end
            end
            S_COF: begin
                n_macc = psum;
                if (r_limb != 2'd2) begin
                    n_limb = r_limb + 2'd1;
                end else begin
                    n_limb = 2'd0;
                    if (r_mstep == 2'd0) begin
                        n_prod  = psum[MC_W-1:0];
                        n_mstep = 2'd1;
                    end else begin
                        n_mstep = 2'd0;
                        n_acc   = psum;
                        if (r_term[2:0] == 3'd5) begin
                            n_term  = '0;
                            n_state = S_PREP;
                        end else begin
                            n_term = r_term + 5'd1;
                        end
                    end
                end
            end
            S_PREP: begin
                // magnitudes and signs, numerator scaled by 2^(2*FRAC_BITS)
                n_dneg = r_det[W-1];
                n_dmag = r_det[W-1] ? -r_det : r_det;
                n_nneg = r_acc[W-1];
                n_num  = {(r_acc[W-1] ? -r_acc : r_acc), {(2*FRAC_BITS){1'b0}}};
                n_rem  = '0;
                n_dcnt = DCNT_W'(DIV_N);
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_dcnt != '0) begin
                    if (!rem_sub[W]) begin
                        n_rem = rem_sub;
                        n_num = {r_num[NUM_W-2:0], 1'b1};
                    end else begin
                        n_rem = rem_sh;
                        n_num = {r_num[NUM_W-2:0], 1'b0};
                    end
                    n_dcnt = r_dcnt - DCNT_W'(1);
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_oidx   = r_k;
                    n_osing  = 1'b0;
                    if (qneg) begin
                        n_osat = qhigh || (qlow > 32'h8000_0000);
                        n_oval = n_osat ? 32'sh8000_0000 : $signed(32'd0 - qlow);
                    end else begin
                        n_osat = qhigh || qlow[31];
                        n_oval = n_osat ? 32'sh7FFF_FFFF : $signed(qlow);
                    end
                    n_acc = '0;
                    n_k   = r_k + 4'd1;
                    n_state = (r_k == 4'd15) ? S_LOAD : S_COF;
                end
            end
            S_SING: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_oidx   = r_k;
                    n_oval   = $signed(r_elem[r_k]);
                    n_osing  = 1'b1;
                    n_osat   = 1'b0;
                    n_k      = r_k + 4'd1;
                    if (r_k == 4'd15) begin
                        n_state = S_LOAD;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_load   <= '0;
            r_term   <= '0;
            r_mstep  <= '0;
            r_limb   <= '0;
            r_k      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_load   <= n_load;
            r_term   <= n_term;
            r_mstep  <= n_mstep;
            r_limb   <= n_limb;
            r_k      <= n_k;
            r_ovalid <= n_ovalid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_det   <= n_det;
        r_acc   <= n_acc;
        r_macc  <= n_macc;
        r_prod  <= n_prod;
        r_dmag  <= n_dmag;
        r_dneg  <= n_dneg;
        r_nneg  <= n_nneg;
        r_num   <= n_num;
        r_rem   <= n_rem;
        r_dcnt  <= n_dcnt;
        r_oval  <= n_oval;
        r_oidx  <= n_oidx;
        r_osing <= n_osing;
        r_osat  <= n_osat;
    end

    assign o_valid        = r_ovalid;
    assign o_result_value = r_oval;
    assign o_result_index = r_oidx;
    assign o_singular     = r_osing;
    assign o_saturated    = r_osat;
    assign o_last         = (r_oidx == 4'd15);

`ifndef NO_ASSERTIONS
    // input is only taken while loading
    a_load_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept_in |-> r_state == S_LOAD)
        else $error("input taken outside load");

    // a stalled result holds its index
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_index))
        else $error("result changed while stalled");

    // singular results never report saturation
    a_sing_nosat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_singular |-> !o_saturated)
        else $error("singular result flagged saturated");

    // last result returns the block to loading
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) && o_last |-> r_state == S_LOAD)
        else $error("last result without return to load");
`endif

endmodule

// ----- sim/testbench.sv -----
// testbench for the 4x4 fixed-point matrix inverse: directed and random matrices
`timescale 1ns / 100ps

module testbench;

    localparam int FRAC = 16;
    localparam int LIMIT_CYCLES = 2000000;
    localparam logic [31:0] ONE_Q = 32'h0001_0000;
    localparam logic [31:0] MIN_S = 32'h8000_0000;
    localparam logic [31:0] MAX_S = 32'h7FFF_FFFF;

    typedef logic signed [255:0] t_big;

    typedef struct {
        logic [31:0] value;
        logic [3:0]  index;
        logic        singular;
        logic        saturated;
        logic        last;
    } t_inv_elem;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_element_value;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_result_value;
    logic [3:0]  o_result_index;
    logic        o_singular;
    logic        o_saturated;
    logic        o_last;

    // predictor state
    logic [31:0] loaded[16];
    int          load_pos;
    t_inv_elem   inverse_q[$];

    bit errors;
    bit idle_en;
    int stall_left;
    int cycles;

    matrix_inverse_4x4 #(.FRAC_BITS(FRAC)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_element_value(i_element_value),
        .o_valid(o_valid), .i_stall(i_stall), .o_result_value(o_result_value),
        .o_result_index(o_result_index), .o_singular(o_singular),
        .o_saturated(o_saturated), .o_last(o_last)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic t_big elem(input int r, input int c);
        return t_big'($signed(loaded[r*4 + c]));
    endfunction

    // determinant of the 3x3 minor left after removing one row and one column
    function automatic t_big minor_det(input int skip_r, input int skip_c);
        int   rs[3];
        int   cs[3];
        int   n;
        t_big m[3][3];
        n = 0;
        for (int i = 0; i < 4; i++) if (i != skip_r) begin rs[n] = i; n++; end
        n = 0;
        for (int i = 0; i < 4; i++) if (i != skip_c) begin cs[n] = i; n++; end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] = elem(rs[i], cs[j]);
        return m[0][0] * (m[1][1] * m[2][2] - m[1][2] * m[2][1])
             - m[0][1] * (m[1][0] * m[2][2] - m[1][2] * m[2][0])
             + m[0][2] * (m[1][0] * m[2][1] - m[1][1] * m[2][0]);
    endfunction

    // expected inverse of the loaded matrix, queued in storage order
    function automatic void predict_inverse();
        t_big      det;
        t_big      cof;
        t_big      num_mag;
        t_big      det_mag;
        t_big      quo;
        bit        neg;
        t_inv_elem e;
        det = 0;
        for (int c = 0; c < 4; c++) begin
            if (c % 2 == 0) det = det + elem(0, c) * minor_det(0, c);
            else            det = det - elem(0, c) * minor_det(0, c);
        end
        det_mag = (det < 0) ? -det : det;
        for (int k = 0; k < 16; k++) begin
            e.index = k[3:0];
            e.last = (k == 15);
            e.saturated = 1'b0;
            if (det == 0) begin
                e.value = loaded[k];
                e.singular = 1'b1;
            end else begin
                e.singular = 1'b0;
                // adjugate: transpose of the signed minors
                cof = minor_det(k % 4, k / 4);
                if (((k / 4) + (k % 4)) % 2 == 1) cof = -cof;
                neg = (cof < 0) != (det < 0);
                num_mag = ((cof < 0) ? -cof : cof) <<< (2 * FRAC);
                quo = num_mag / det_mag;
                if (neg) begin
                    if (quo > t_big'(64'h8000_0000)) begin
                        e.value = MIN_S;
                        e.saturated = 1'b1;
                    end else begin
                        e.value = -quo[31:0];
                    end
                end else begin
                    if (quo > t_big'(64'h7FFF_FFFF)) begin
                        e.value = MAX_S;
                        e.saturated = 1'b1;
                    end else begin
                        e.value = quo[31:0];
                    end
                end
            end
            inverse_q.push_back(e);
        end
    endfunction

    // one element transfer, with an optional idle burst in front
    task automatic send_element(input logic [31:0] v);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_element_value <= v;
        do @(posedge i_clk); while (o_stall);
        loaded[load_pos] = v;
        if (load_pos == 15) begin
            load_pos = 0;
            predict_inverse();
        end else begin
            load_pos++;
        end
    endtask

    task automatic send_matrix(input logic [31:0] m[16]);
        for (int i = 0; i < 16; i++) send_element(m[i]);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (inverse_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_identity();
        logic [31:0] m[16];
        for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? ONE_Q : 32'h0;
        send_matrix(m);
        // scaled permutation matrix with a negative entry: positive determinant
        for (int i = 0; i < 16; i++) m[i] = 32'h0;
        m[1] = ONE_Q; m[4] = ONE_Q; m[10] = 32'hFFFE_0000; m[15] = 32'h0003_0000;
        send_matrix(m);
    endtask

    task automatic test_singular();
        logic [31:0] m[16];
        for (int i = 0; i < 16; i++) m[i] = MIN_S;
        send_matrix(m);
        for (int i = 0; i < 16; i++) m[i] = MAX_S;
        send_matrix(m);
    endtask

    task automatic test_saturation();
        logic [31:0] m[16];
        // tiny diagonal: inverse far beyond range, positive and negative
        for (int i = 0; i < 16; i++) m[i] = 32'h0;
        m[0] = 32'h1; m[5] = 32'hFFFF_FFFF; m[10] = 32'h1; m[15] = 32'h2;
        send_matrix(m);
    endtask

    task automatic test_random(input int n_mat);
        logic [31:0] m[16];
        int          kind;
        int          src;
        for (int n = 0; n < n_mat; n++) begin
            if (n == n_mat - 3) idle_en = 0;
            kind = $urandom_range(0, 4);
            for (int i = 0; i < 16; i++) begin
                case (kind)
                    0: m[i] = {16'($signed($urandom_range(0, 8)) - 16'sd4), 16'h0};
                    1: m[i] = $urandom;
                    2: m[i] = $urandom;
                    3: m[i] = (i % 5 == 0) ? 32'h0008_0000 + $urandom_range(0, 32'hFFFFF)
                                           : $urandom_range(0, 32'h1FFFF) - 32'h1_0000;
                    default: m[i] = $urandom_range(0, 16) - 8;
                endcase
            end
            // singular: one row repeats another
            if (kind == 2) begin
                src = $urandom_range(0, 3);
                for (int c = 0; c < 4; c++) m[((src + 1) % 4) * 4 + c] = m[src * 4 + c];
            end
            send_matrix(m);
            if (n == 4) wait_drained();
        end
    endtask

    // receiver stall bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 6);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // result checking
    always @(posedge i_clk) begin
        t_inv_elem e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (inverse_q.size() == 0) begin
                $error("unexpected result transfer, index %0d", o_result_index);
                errors = 1;
            end else begin
                e = inverse_q.pop_front();
                if (o_result_value !== e.value) begin
                    $error("result_value exp %h got %h", e.value, o_result_value);
                    errors = 1;
                end
                if (o_result_index !== e.index) begin
                    $error("result_index exp %0d got %0d", e.index, o_result_index);
                    errors = 1;
                end
                if (o_singular !== e.singular) begin
                    $error("singular exp %b got %b", e.singular, o_singular);
                    errors = 1;
                end
                if (o_saturated !== e.saturated) begin
                    $error("saturated exp %b got %b", e.saturated, o_saturated);
                    errors = 1;
                end
                if (o_last !== e.last) begin
                    $error("last exp %b got %b", e.last, o_last);
                    errors = 1;
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        errors = 0;
        idle_en = 1;
        stall_left = 0;
        cycles = 0;
        load_pos = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_element_value = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_identity();
        test_singular();
        test_saturation();
        test_random(21);
        i_valid <= 1'b0;
        wait_drained();
        repeat (50) @(posedge i_clk);
        if (errors == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/mi4_pkg.sv
rtl/matrix_inverse_4x4.sv
sim/testbench.sv
